>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every edge outside reset
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// property checked on every edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/idrr_pkg.sv
// ----------------------------------------------------------------------------
// idrr_pkg
// Types and constants of the int8 dense / ReLU / requantize block.
// ----------------------------------------------------------------------------
package idrr_pkg;

    localparam int LANES    = 4;
    localparam int ACT_W    = 8;
    localparam int PROD_W   = 2 * ACT_W;
    localparam int ACC_W    = 32;
    localparam int COEF_W   = 32;
    localparam int NL_W     = 3;
    localparam int CLAMP_W  = 7;
    localparam int MUL_W    = ACC_W + COEF_W;
    localparam int FRAC_W   = 24;    // scale is Q8.24
    localparam int BIAS_SH  = 8;     // Q16.16 -> Q.24

    localparam logic [CLAMP_W-1:0] CLAMP_RESET = 7'd127;

    // slave tdata layout, lowest bit first
    localparam int ACT_LSB   = 0;
    localparam int WT_LSB    = ACT_LSB + LANES * ACT_W;
    localparam int NL_LSB    = WT_LSB + LANES * ACT_W;
    localparam int SCALE_LSB = NL_LSB + NL_W;
    localparam int BIAS_LSB  = SCALE_LSB + COEF_W;
    localparam int S_RAW_W   = BIAS_LSB + COEF_W;
    localparam int S_TDATA_W = ((S_RAW_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((CLAMP_W + 7) / 8) * 8;

    typedef logic signed [PROD_W-1:0] t_prod;

    // finished dot product handed to the requantizer
    typedef struct packed {
        logic signed [ACC_W-1:0]  acc;
        logic signed [COEF_W-1:0] scale;
        logic signed [COEF_W-1:0] bias;
    } t_req;

endpackage

>>> hw/rtl/idrr_lane.sv
// ----------------------------------------------------------------------------
// idrr_lane
// One multiply lane: registered signed 8x8 product, zero when the lane is off.
// ----------------------------------------------------------------------------
module idrr_lane (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic                             i_active,
    input  logic signed [idrr_pkg::ACT_W-1:0] i_act,
    input  logic signed [idrr_pkg::ACT_W-1:0] i_wt,
    output idrr_pkg::t_prod                  o_prod
);
    import idrr_pkg::*;

    t_prod r_prod;
    t_prod n_prod;

    always_comb begin
        n_prod = i_active ? t_prod'(i_act * i_wt) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
        end
    end

    assign o_prod = r_prod;

endmodule

>>> hw/rtl/idrr_merge.sv
// ----------------------------------------------------------------------------
// idrr_merge
// Sums the lane products into the running accumulator; on the last
// transaction of a neuron hands the total on and clears the accumulator.
// ----------------------------------------------------------------------------
module idrr_merge (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  idrr_pkg::t_prod      i_prods [idrr_pkg::LANES],
    input  logic                 i_last,
    input  logic signed [idrr_pkg::COEF_W-1:0] i_scale,
    input  logic signed [idrr_pkg::COEF_W-1:0] i_bias,
    output logic                 o_valid,
    input  logic                 i_ready,
    output idrr_pkg::t_req       o_req
);
    import idrr_pkg::*;

    logic signed [ACC_W-1:0] r_acc;
    logic signed [ACC_W-1:0] n_acc;
    logic signed [ACC_W-1:0] lane_sum;
    logic                    r_vld;
    t_req                    r_req;
    logic                    take;

    always_comb begin
        lane_sum = '0;
        for (int i = 0; i < LANES; i++) begin
            lane_sum = lane_sum + {{(ACC_W-PROD_W){i_prods[i][PROD_W-1]}}, i_prods[i]};
        end
        n_acc = r_acc + lane_sum;   // wraps mod 2^32
    end

    assign o_ready = !r_vld || i_ready;
    assign take    = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_vld <= 1'b0;
        end else begin
            // a new total replaces the one leaving in the same cycle
            if (take && i_last) begin
                r_vld <= 1'b1;
            end else if (i_ready) begin
                r_vld <= 1'b0;
            end
            if (take) begin
                if (i_last) begin
                    r_acc <= '0;
                end else begin
                    r_acc <= n_acc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && i_last) begin
            r_req.acc   <= n_acc;
            r_req.scale <= i_scale;
            r_req.bias  <= i_bias;
        end
    end

    assign o_valid = r_vld;
    assign o_req   = r_req;

endmodule

>>> hw/rtl/idrr_requant.sv
// ----------------------------------------------------------------------------
// idrr_requant
// Scale multiply, bias add, floor and clamp to 0..clamp_max, two stages.
// ----------------------------------------------------------------------------
module idrr_requant (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  idrr_pkg::t_req                i_req,
    input  logic [idrr_pkg::CLAMP_W-1:0]  i_clamp_max,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [idrr_pkg::CLAMP_W-1:0]  o_value
);
    import idrr_pkg::*;

    // multiply stage
    logic                     r_m_vld;
    logic signed [MUL_W-1:0]  r_mul;
    logic signed [COEF_W-1:0] r_bias;
    // output stage
    logic                     r_o_vld;
    logic [CLAMP_W-1:0]       r_o_val;
    logic [CLAMP_W-1:0]       n_o_val;

    logic                     m_ready;
    logic                     o_stage_ready;
    logic signed [MUL_W-1:0]  total;

    assign o_stage_ready = !r_o_vld || i_ready;
    assign m_ready       = !r_m_vld || o_stage_ready;
    assign o_ready       = m_ready;

    always_comb begin
        total = r_mul + {{(MUL_W-COEF_W-BIAS_SH){r_bias[COEF_W-1]}}, r_bias, {BIAS_SH{1'b0}}};
        if (total[MUL_W-1]) begin
            n_o_val = '0;           // any negative value, fractions included
        end else if ((|total[MUL_W-2:FRAC_W+CLAMP_W])
                     || (total[FRAC_W+CLAMP_W-1:FRAC_W] > i_clamp_max)) begin
            n_o_val = i_clamp_max;
        end else begin
            n_o_val = total[FRAC_W+CLAMP_W-1:FRAC_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            if (m_ready) begin
                r_m_vld <= i_valid;
            end
            if (o_stage_ready) begin
                r_o_vld <= r_m_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (m_ready && i_valid) begin
            r_mul  <= i_req.acc * i_req.scale;
            r_bias <= i_req.bias;
        end
        if (o_stage_ready && r_m_vld) begin
            r_o_val <= n_o_val;
        end
    end

    assign o_valid = r_o_vld;
    assign o_value = r_o_val;

endmodule

>>> hw/rtl/int8_dense_relu_requant.sv
// ----------------------------------------------------------------------------
// int8_dense_relu_requant
// One output neuron of a quantized int8 fully connected layer with ReLU/ReLU6.
// ----------------------------------------------------------------------------
// Takes one transaction per clock unless stalled: four signed 8-bit
// activation/weight pairs (lanes_valid of them used), multiplied in four
// parallel lanes and summed into a 32-bit wrapping accumulator in the merge
// stage. On a tlast transaction the total is multiplied by the Q8.24 scale,
// the Q16.16 bias is added, and the floored value is clamped to 0..clamp_max;
// the result passes the lane, merge, multiply and output registers to the
// master side. The accumulator clears on tlast, so the next neuron may follow
// directly. clamp_max resets to 127 and is written through the cfg channel,
// which is always ready; write it only while no result is pending.
module int8_dense_relu_requant (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // act0..act3, wt0..wt3, lanes_valid[2:0], scale[31:0], bias[31:0], zero pad
    input  logic [idrr_pkg::S_TDATA_W-1:0]      i_s_axis_tdata,
    input  logic                                i_s_axis_tlast,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // out_value[6:0], zero pad
    output logic [idrr_pkg::M_TDATA_W-1:0]      o_m_axis_tdata,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [idrr_pkg::CLAMP_W-1:0]        i_cfg_data
);
    import idrr_pkg::*;

    logic [CLAMP_W-1:0]       r_clamp_max;

    // lane stage
    logic                     r_s0_vld;
    logic                     r_s0_last;
    logic signed [COEF_W-1:0] r_s0_scale;
    logic signed [COEF_W-1:0] r_s0_bias;
    logic                     s0_ready;
    logic                     s0_load;
    logic [NL_W-1:0]          lanes_valid;
    t_prod                    prods [LANES];

    logic                     mg_ready;
    logic                     mg_valid;
    t_req                     mg_req;
    logic                     rq_ready;
    logic [CLAMP_W-1:0]       rq_value;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clamp_max <= CLAMP_RESET;
        end else if (i_cfg_valid) begin
            r_clamp_max <= i_cfg_data;
        end
    end

    assign lanes_valid     = i_s_axis_tdata[NL_LSB +: NL_W];
    assign s0_ready        = !r_s0_vld || mg_ready;
    assign s0_load         = i_s_axis_tvalid && s0_ready;
    assign o_s_axis_tready = s0_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
        end else if (s0_ready) begin
            r_s0_vld <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s0_load) begin
            r_s0_last  <= i_s_axis_tlast;
            r_s0_scale <= i_s_axis_tdata[SCALE_LSB +: COEF_W];
            r_s0_bias  <= i_s_axis_tdata[BIAS_LSB +: COEF_W];
        end
    end

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        idrr_lane u_lane (
            .i_clk    (i_clk),
            .i_en     (s0_load),
            // counts above LANES saturate naturally
            .i_active (lanes_valid > NL_W'(g)),
            .i_act    (i_s_axis_tdata[ACT_LSB + g*ACT_W +: ACT_W]),
            .i_wt     (i_s_axis_tdata[WT_LSB + g*ACT_W +: ACT_W]),
            .o_prod   (prods[g])
        );
    end

    idrr_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s0_vld),
        .o_ready (mg_ready),
        .i_prods (prods),
        .i_last  (r_s0_last),
        .i_scale (r_s0_scale),
        .i_bias  (r_s0_bias),
        .o_valid (mg_valid),
        .i_ready (rq_ready),
        .o_req   (mg_req)
    );

    idrr_requant u_requant (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (mg_valid),
        .o_ready     (rq_ready),
        .i_req       (mg_req),
        .i_clamp_max (r_clamp_max),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_value     (rq_value)
    );

    assign o_m_axis_tdata = {{(M_TDATA_W-CLAMP_W){1'b0}}, rq_value};

endmodule

>>> hw/rtl/idrr_checker.sv
// ----------------------------------------------------------------------------
// idrr_checker
// Port-level checks of the dense/ReLU/requantize block, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module idrr_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [idrr_pkg::M_TDATA_W-1:0]      o_m_axis_tdata,
    input  logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    input  logic                                i_cfg_valid,
    input  logic                                o_cfg_ready,
    input  logic [idrr_pkg::CLAMP_W-1:0]        i_cfg_data
);
    import idrr_pkg::*;

    // shadow of the clamp register, tracked from cfg transactions
    logic [CLAMP_W-1:0] r_clamp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clamp <= CLAMP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_clamp <= i_cfg_data;
        end
    end

    `ASSERT_RST(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid, "result dropped while stalled")
    `ASSERT_RST(a_out_stable, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata), "result changed while stalled")
    `ASSERT_RST(a_out_clamp, i_clk, i_rst_n, o_m_axis_tvalid |-> (o_m_axis_tdata[CLAMP_W-1:0] <= r_clamp) && (o_m_axis_tdata[M_TDATA_W-1:CLAMP_W] == '0), "result above clamp_max")
    `ASSERT_ALWAYS(a_rst_clear, i_clk, !i_rst_n |=> !o_m_axis_tvalid, "result valid after reset")

endmodule

bind int8_dense_relu_requant idrr_checker u_idrr_checker (.*);
